@@ hdl/mu8_pkg.sv @@
// Shared types and constants for the modified UTF-8 decoder.
`default_nettype none
package mu8_pkg;

	localparam int BYTE_W         = 8;
	localparam int UNIT_W         = 16;
	localparam int COUNT_BITS_DEF = 16;

	// result kinds
	localparam logic KIND_UNIT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_STRAY = 2'd1;
	localparam logic [1:0] ERR_TRUNC = 2'd2;

	// continuation bytes still expected
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	// byte masks
	localparam logic [7:0] MASK_HI   = 8'h80;
	localparam logic [7:0] MASK_B6   = 8'h40;
	localparam logic [7:0] MASK_B5   = 8'h20;
	localparam logic [7:0] MASK_LEAD3 = 8'h0f;
	localparam logic [7:0] MASK_LEAD2 = 8'h1f;
	localparam logic [7:0] MASK_CONT = 8'h3f;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              kind;
		logic [UNIT_W-1:0] unit_count;
		logic [1:0]        error_code;
	} res_t;

endpackage
`default_nettype wire

@@ hdl/mu8_byte_if.sv @@
// Byte input channel: valid, ready and one byte of payload.
`default_nettype none
interface mu8_byte_if import mu8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/mu8_result_if.sv @@
// Result channel: valid, ready and one decoded result.
`default_nettype none
interface mu8_result_if import mu8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              kind;
	logic [UNIT_W-1:0] unit_count;
	logic [1:0]        error_code;

	modport source (output valid, output code_unit, output kind, output unit_count,
		output error_code, input ready);
	modport sink   (input valid, input code_unit, input kind, input unit_count,
		input error_code, output ready);
endinterface
`default_nettype wire

@@ hdl/mu8_decode.sv @@
// Per-byte decode step: next decoder state and the result, if any.
`default_nettype none
module mu8_decode import mu8_pkg::*; #(
	parameter int CNT_W = 16
) (
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic [1:0]        pend,
	input  wire logic [UNIT_W-1:0] partial,
	input  wire logic [CNT_W-1:0]  count,
	output logic [1:0]             pend_nxt,
	output logic [UNIT_W-1:0]      partial_nxt,
	output logic [CNT_W-1:0]       count_nxt,
	output logic                   has_res,
	output res_t                   res
);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	logic [CNT_W-1:0] count_inc;
	logic [7:0]       b;

	assign b         = in_byte;
	assign count_inc = (count == CNT_MAX) ? count : count + CNT_W'(1);

	always_comb begin
		pend_nxt       = pend;
		partial_nxt    = partial;
		count_nxt      = count;
		has_res        = 1'b0;
		res.code_unit  = '0;
		res.kind       = KIND_UNIT;
		res.unit_count = UNIT_W'(count);
		res.error_code = ERR_NONE;

		if (b == 8'h00) begin
			// terminator: report and clear everything
			has_res        = 1'b1;
			res.kind       = KIND_END;
			res.error_code = (pend != PEND_NONE) ? ERR_TRUNC : ERR_NONE;
			pend_nxt       = PEND_NONE;
			partial_nxt    = '0;
			count_nxt      = '0;
		end else begin
			unique case (pend)
				PEND_NONE: begin
					if ((b & MASK_HI) == 8'h00) begin
						has_res        = 1'b1;
						count_nxt      = count_inc;
						res.code_unit  = UNIT_W'(b);
						res.unit_count = UNIT_W'(count_inc);
					end else if ((b & MASK_B6) == 8'h00) begin
						// stray continuation where a lead belongs
						has_res        = 1'b1;
						res.error_code = ERR_STRAY;
					end else if ((b & MASK_B5) != 8'h00) begin
						partial_nxt = UNIT_W'(b & MASK_LEAD3) << 12;
						pend_nxt    = PEND_TWO;
					end else begin
						partial_nxt = UNIT_W'(b & MASK_LEAD2) << 6;
						pend_nxt    = PEND_ONE;
					end
				end
				PEND_TWO: begin
					partial_nxt = partial | (UNIT_W'(b & MASK_CONT) << 6);
					pend_nxt    = PEND_ONE;
				end
				default: begin
					// last continuation byte completes the unit
					has_res        = 1'b1;
					count_nxt      = count_inc;
					res.code_unit  = partial | UNIT_W'(b & MASK_CONT);
					res.unit_count = UNIT_W'(count_inc);
					partial_nxt    = '0;
					pend_nxt       = PEND_NONE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/modified_utf8_decoder.sv @@
// Top level of the Java modified UTF-8 decoder.
//
// Decodes a zero-terminated modified UTF-8 byte stream into 16-bit code
// units. Each byte is taken into an input register, decoded combinationally
// against the sequence state, and its result, if any, lands in an output
// register; one byte can be accepted every cycle unless one with a result
// waits on a full output register, and a byte that yields no result (lead
// or middle byte) moves on even while a finished result waits downstream.
// An ASCII byte or the last byte of a two- or three-byte sequence gives
// one unit (kind 0). A zero byte gives an end result (kind 1) whose
// unit_count is the number of units in the string, saturating at the
// smaller of 2^COUNT_BITS-1 and 65535, and error_code 2 if it cut a
// sequence short; the count and sequence state then clear. A stray
// 10xxxxxx lead is dropped and reported as kind 0, code_unit 0,
// error_code 1, with the count unchanged. Continuation bytes are not checked.
`default_nettype none
module modified_utf8_decoder import mu8_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	mu8_byte_if.sink    bytes,
	mu8_result_if.source units
);

	// counter never needs more than the 16 bits the result field carries
	localparam int CNT_W = (COUNT_BITS < UNIT_W) ? COUNT_BITS : UNIT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// sequence state
	logic [1:0]        pend_q;
	logic [UNIT_W-1:0] partial_q;
	logic [CNT_W-1:0]  count_q;

	// output register
	logic out_valid_q;
	res_t res_q;

	// decode outputs
	logic [1:0]        pend_nxt;
	logic [UNIT_W-1:0] partial_nxt;
	logic [CNT_W-1:0]  count_nxt;
	logic              has_res;
	res_t              res;

	logic out_free;
	logic s1_fire;

	mu8_decode #(.CNT_W(CNT_W)) u_decode (
		.in_byte     (byte_s1),
		.pend        (pend_q),
		.partial     (partial_q),
		.count       (count_q),
		.pend_nxt    (pend_nxt),
		.partial_nxt (partial_nxt),
		.count_nxt   (count_nxt),
		.has_res     (has_res),
		.res         (res)
	);

	// output slot is free if empty or being drained this cycle
	assign out_free = !out_valid_q || units.ready;
	// a byte without a result never waits on the output
	assign s1_fire  = valid_s1 && (!has_res || out_free);
	assign bytes.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
		end
	end

	// state advances only when the byte in s1 is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= PEND_NONE;
			partial_q <= '0;
			count_q   <= '0;
		end else if (s1_fire) begin
			pend_q    <= pend_nxt;
			partial_q <= partial_nxt;
			count_q   <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && has_res) begin
			out_valid_q <= 1'b1;
		end else if (units.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_res) begin
			res_q <= res;
		end
	end

	assign units.valid      = out_valid_q;
	assign units.code_unit  = res_q.code_unit;
	assign units.kind       = res_q.kind;
	assign units.unit_count = res_q.unit_count;
	assign units.error_code = res_q.error_code;

	// terminator clears the string state
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && byte_s1 == 8'h00 |=> count_q == '0 && pend_q == PEND_NONE)
		else $error("state not cleared after terminator");

	// an empty output slot never stalls the input
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> bytes.ready)
		else $error("input stalled with free output slot");

	// a dropped stray lead leaves the count alone
	a_stray_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && has_res && res.error_code == ERR_STRAY |=> $stable(count_q))
		else $error("stray lead changed the unit count");

	// a saturated count stays saturated until the string ends
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_MAX |=> count_q == CNT_MAX || count_q == '0)
		else $error("unit count wrapped");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the modified UTF-8 decoder: stimulus, prediction and checking.
`timescale 1ns / 1ps
module testbench;
	import mu8_pkg::*;

	// Count width used for the instance; the predictor saturates at the same bound.
	localparam int TB_COUNT_BITS = COUNT_BITS_DEF;
	localparam logic [UNIT_W-1:0] COUNT_MAX = (TB_COUNT_BITS >= UNIT_W) ? 16'hFFFF :
		16'((64'd1 << TB_COUNT_BITS) - 64'd1);

	localparam int RESET_CYCLES   = 5;
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for the backpressure test
	localparam int DRAIN_CYCLES   = 10;    // extra drain time after the expectation queue empties
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either channel
	localparam int MAX_REPORTS    = 10;

	logic clk = 1'b0;
	logic arst_n;

	mu8_byte_if   byte_ch ();
	mu8_result_if unit_ch ();

	modified_utf8_decoder #(
		.COUNT_BITS(TB_COUNT_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (byte_ch),
		.units (unit_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow decoder state, advanced once per accepted byte
	// ------------------------------------------------------------------
	logic [1:0]        shadow_pend;
	logic [UNIT_W-1:0] shadow_partial;
	logic [UNIT_W-1:0] shadow_count;

	res_t expected_results[$];

	// Traffic knobs, changed by the test tasks
	bit source_idle_on = 1'b1;
	bit sink_idle_on   = 1'b1;
	bit hold_request   = 1'b0;

	int bytes_sent      = 0;
	int results_checked = 0;
	int strings_closed  = 0;
	int mismatches      = 0;
	int idle_cycles     = 0;

	// Saturating unit counter of the current string
	function automatic void bump_unit_count();
		if (shadow_count < COUNT_MAX)
			shadow_count = shadow_count + 1'b1;
	endfunction

	// Advance the shadow state by one byte. Returns 1 when the byte yields a
	// result, which is then placed in r.
	function automatic bit decode_next_byte(input logic [BYTE_W-1:0] b, output res_t r);
		r = '0;
		r.kind = KIND_UNIT;
		r.error_code = ERR_NONE;
		// A zero byte always closes the string, even in the middle of a sequence.
		if (b == 8'h00) begin
			r.kind       = KIND_END;
			r.unit_count = shadow_count;
			r.error_code = (shadow_pend != PEND_NONE) ? ERR_TRUNC : ERR_NONE;
			shadow_pend    = PEND_NONE;
			shadow_partial = '0;
			shadow_count   = '0;
			return 1'b1;
		end
		if (shadow_pend == PEND_NONE) begin
			// Plain ASCII: one unit straight through.
			if ((b & MASK_HI) == 8'h00) begin
				bump_unit_count();
				r.code_unit  = {8'h00, b};
				r.unit_count = shadow_count;
				return 1'b1;
			end
			// 10xxxxxx where a lead belongs: dropped, flagged, not counted.
			if ((b & MASK_B6) == 8'h00) begin
				r.unit_count = shadow_count;
				r.error_code = ERR_STRAY;
				return 1'b1;
			end
			// 111xxxxx starts three bytes (F0..FF included), 110xxxxx starts two.
			if ((b & MASK_B5) != 8'h00) begin
				shadow_partial = UNIT_W'(b & MASK_LEAD3) << 12;
				shadow_pend    = PEND_TWO;
			end else begin
				shadow_partial = UNIT_W'(b & MASK_LEAD2) << 6;
				shadow_pend    = PEND_ONE;
			end
			return 1'b0;
		end
		// Continuation bytes: low six bits taken, top bits ignored.
		if (shadow_pend == PEND_TWO) begin
			shadow_partial = shadow_partial | (UNIT_W'(b & MASK_CONT) << 6);
			shadow_pend    = PEND_ONE;
			return 1'b0;
		end
		shadow_partial = shadow_partial | UNIT_W'(b & MASK_CONT);
		shadow_pend    = PEND_NONE;
		bump_unit_count();
		r.code_unit    = shadow_partial;
		r.unit_count   = shadow_count;
		shadow_partial = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Byte sender: optional idle burst, then hold valid until the transfer
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int   gap;
		res_t r;
		if (source_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
		if (decode_next_byte(b, r))
			expected_results.push_back(r);
	endtask

	// Continuation byte; when not well formed it may have any nonzero value.
	function automatic logic [BYTE_W-1:0] cont_byte(input bit well_formed);
		logic [BYTE_W-1:0] b;
		if (well_formed)
			b = MASK_HI | BYTE_W'($urandom_range(0, 63));
		else
			b = BYTE_W'($urandom_range(1, 255));
		return b;
	endfunction

	// One string of random units, closed by a zero byte. Broken strings mix in
	// stray leads, cut sequences and arbitrary bytes.
	task automatic send_random_string(input bit well_formed);
		int                n_units;
		int                i;
		logic [BYTE_W-1:0] b;
		n_units = $urandom_range(0, 12);
		for (i = 0; i < n_units; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					b = BYTE_W'($urandom_range(1, 127));
					send_byte(b);
				end
				4, 5: begin
					b = 8'hC0 | BYTE_W'($urandom_range(0, 31));
					send_byte(b);
					send_byte(cont_byte(well_formed));
				end
				6, 7: begin
					b = 8'hE0 | BYTE_W'($urandom_range(0, 31));
					send_byte(b);
					send_byte(cont_byte(well_formed));
					send_byte(cont_byte(well_formed));
				end
				8: begin
					// overlong zero
					send_byte(8'hC0);
					send_byte(8'h80);
				end
				default: begin
					if (well_formed) begin
						b = BYTE_W'($urandom_range(1, 127));
						send_byte(b);
					end else begin
						case ($urandom_range(0, 2))
							0: send_byte(MASK_HI | BYTE_W'($urandom_range(0, 63)));
							1: begin
								b = 8'hC0 | BYTE_W'($urandom_range(0, 63));
								send_byte(b);
								if (b[5]) send_byte(cont_byte(1'b1));
								send_byte(8'h00);
							end
							default: send_byte(BYTE_W'($urandom_range(1, 255)));
						endcase
					end
				end
			endcase
		end
		send_byte(8'h00);
	endtask

	// ------------------------------------------------------------------
	// Receiver ready: random stall bursts, plus the long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		unit_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				unit_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				unit_ch.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				unit_ch.ready <= 1'b0;
			end else begin
				unit_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each transfer against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t exp_r;
		res_t act_r;
		if (arst_n && unit_ch.valid && unit_ch.ready) begin
			act_r.code_unit  = unit_ch.code_unit;
			act_r.kind       = unit_ch.kind;
			act_r.unit_count = unit_ch.unit_count;
			act_r.error_code = unit_ch.error_code;
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result unit=%h kind=%0d count=%0d err=%0d",
						$realtime, act_r.code_unit, act_r.kind, act_r.unit_count,
						act_r.error_code);
			end else begin
				exp_r = expected_results.pop_front();
				if (act_r.kind == KIND_END)
					strings_closed++;
				if (act_r.code_unit !== exp_r.code_unit || act_r.kind !== exp_r.kind ||
					act_r.unit_count !== exp_r.unit_count ||
					act_r.error_code !== exp_r.error_code) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: mismatch expected unit=%h kind=%0d count=%0d err=%0d",
							" actual unit=%h kind=%0d count=%0d err=%0d"}, $realtime,
							exp_r.code_unit, exp_r.kind, exp_r.unit_count, exp_r.error_code,
							act_r.code_unit, act_r.kind, act_r.unit_count, act_r.error_code);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without a transfer on either side ends the run
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$realtime, idle_cycles, expected_results.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Lowest and highest nonzero ASCII bytes.
	task automatic test_ascii();
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'h00);
	endtask

	// Two-byte units: overlong zero, top of range, continuation whose top bits are not 10.
	task automatic test_two_byte();
		send_byte(8'hC0); send_byte(8'h80);
		send_byte(8'hDF); send_byte(8'hBF);
		send_byte(8'hC1); send_byte(8'h41);
		send_byte(8'h00);
	endtask

	// Three-byte units: 0xFFFF, and an F0..FF lead with unchecked continuations.
	task automatic test_three_byte();
		send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
		send_byte(8'hF5); send_byte(8'hC0); send_byte(8'h7F);
		send_byte(8'h00);
	endtask

	// Stray continuation leads are dropped and leave the count alone.
	task automatic test_stray_lead();
		send_byte(8'h80);
		send_byte(8'h41);
		send_byte(8'hBF);
		send_byte(8'h00);
	endtask

	// Zero byte cutting a sequence after one and after two bytes, then an empty string.
	task automatic test_truncation();
		send_byte(8'hC3); send_byte(8'h00);
		send_byte(8'hE4); send_byte(8'hB8); send_byte(8'h00);
		send_byte(8'h00);
	endtask

	// Receiver holds off while the sender keeps offering; the block must fill and stall.
	task automatic test_backpressure();
		int i;
		source_idle_on = 1'b0;
		hold_request   = 1'b1;
		for (i = 0; i < 40; i++)
			send_byte(BYTE_W'($urandom_range(1, 127)));
		send_byte(8'h00);
		source_idle_on = 1'b1;
	endtask

	// Mostly well-formed random strings; stretches with and without idling.
	task automatic test_random_strings();
		int start;
		start = bytes_sent;
		source_idle_on = 1'b1;
		sink_idle_on   = 1'b1;
		while (bytes_sent - start < 500)
			send_random_string($urandom_range(0, 3) != 0);
		source_idle_on = 1'b0;
		sink_idle_on   = 1'b0;
		while (bytes_sent - start < 700)
			send_random_string($urandom_range(0, 3) != 0);
		source_idle_on = 1'b1;
		sink_idle_on   = 1'b1;
		while (bytes_sent - start < 1150)
			send_random_string($urandom_range(0, 3) != 0);
		// closing part of the run runs without idling
		source_idle_on = 1'b0;
		sink_idle_on   = 1'b0;
		while (bytes_sent - start < 1350)
			send_random_string($urandom_range(0, 3) != 0);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		shadow_pend    = PEND_NONE;
		shadow_partial = '0;
		shadow_count   = '0;
		byte_ch.valid   <= 1'b0;
		byte_ch.in_byte <= '0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii();
		test_two_byte();
		test_three_byte();
		test_stray_lead();
		test_truncation();
		test_backpressure();
		test_random_strings();

		byte_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", expected_results.size());
		end

		$display("Sent %0d bytes (ASCII, two- and three-byte units, stray leads, cut sequences).",
			bytes_sent);
		$display("Checked %0d results over %0d strings, with a long output stall; %0d mismatches.",
			results_checked, strings_closed, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
